// File: hw/rtl/gec_pkg.sv
`default_nettype none
package gec_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int CHANNELS_DEF = 2;
  localparam int MAX_HOLD_DEF = 4096;

  localparam int CFG_AW = 5;
  localparam int PER_W  = 17;

  // datapath widths
  localparam int A_W    = 34;
  localparam int B_W    = 30;
  localparam int P_W    = A_W + B_W + 1;
  localparam int ACC_W  = 68;
  localparam int DRY_W  = 28;
  localparam int WET_W  = 34;
  localparam int CRD_W  = 43;
  localparam int Z_W    = 33;
  localparam int U_W    = 24;
  localparam int N_W    = 42;
  localparam int NUM_W  = 66;
  localparam int IDX_CW = 5;

  localparam int CORDIC_STEPS = 28;

  localparam logic [30:0]    HALF_PI_Q30     = 31'h6487ED51;
  localparam logic [29:0]    TWO_OVER_PI_Q30 = 30'd683565276;
  localparam logic [U_W-1:0] ONE_Q23         = 24'h800000;

  // register map
  localparam logic [2:0] REG_ENABLES     = 3'd0;
  localparam logic [2:0] REG_INPUT_GAIN  = 3'd1;
  localparam logic [2:0] REG_DRIVE_GAIN  = 3'd2;
  localparam logic [2:0] REG_DIST_AMOUNT = 3'd3;
  localparam logic [2:0] REG_CRUSH_STEP  = 3'd4;
  localparam logic [2:0] REG_HOLD_PERIOD = 3'd5;
  localparam logic [2:0] REG_WET_WEIGHT  = 3'd6;
  localparam logic [2:0] REG_DRY_WEIGHT  = 3'd7;

  // enable bits
  localparam int EN_DRIVE = 0;
  localparam int EN_DIST  = 1;
  localparam int EN_CRUSH = 2;
  localparam int EN_HOLD  = 3;

  typedef enum logic [3:0] {
    A_S, A_DRY, A_WET, A_WET_EFF, A_Z, A_U, A_U2, A_U4, A_U6, A_C135135
  } a_sel_t;

  typedef enum logic [4:0] {
    B_IG, B_DG, B_AMT, B_K2PI, B_P23, B_C17325, B_C378, B_ONE,
    B_C62370, B_C3150, B_C28, B_NLO, B_NHI, B_WW, B_DW, B_U, B_U2
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_CLR, ACC_ADD, ACC_ADD21
  } acc_op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_DRY, DST_WET, DST_V, DST_U, DST_U2, DST_U4, DST_U6,
    DST_N, DST_D, DST_NUM, DST_FIN
  } dst_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DRY, ST_DRV, ST_AMT, ST_CORD, ST_U, ST_U2, ST_U4, ST_U6,
    ST_N0, ST_N1, ST_N2, ST_N3, ST_D0, ST_D1, ST_D2, ST_D3, ST_P0, ST_P1,
    ST_TDIV, ST_CDIV, ST_F0, ST_F1, ST_DONE
  } gec_state_t;

  typedef struct packed {
    logic              ld_in;
    logic              mul_go;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc_op;
    dst_t              dst;
    logic              cord_step;
    logic [IDX_CW-1:0] cord_idx;
    logic              div_go;
    logic              div_crush;
    logic              div_wb;
    logic              commit;
  } gec_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } gec_sts_t;

  function automatic logic [29:0] atan_q30(input logic [IDX_CW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000007;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/guitar_effect_chain.sv
// flow: a word is accepted only in idle, so the next word waits until the last one
// is committed; the steps run on the shared 34x30 multiplier, the 28-step cordic
// and the divider; drive gain and distortion add multiply steps, bit crush and
// distortion each add a divide, and an untaken output word stalls the last step
// reset: synchronous active-low rst_n restores defaults, clears phases, empties output
`default_nettype none
module guitar_effect_chain #(
  parameter int CHANNELS = gec_pkg::CHANNELS_DEF,
  parameter int MAX_HOLD = gec_pkg::MAX_HOLD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [gec_pkg::SAMPLE_BITS-1:0] in_tdata,  // sample_in
  input  wire logic [1:0]                     in_tuser,  // channel, block_start
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [gec_pkg::SAMPLE_BITS-1:0]     out_tdata, // sample_out
  output logic                                out_tuser, // channel_out
  // register port
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [gec_pkg::CFG_AW-1:0]     cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import gec_pkg::*;

  logic [3:0]  enables_r;
  logic [15:0] input_gain_r, drive_gain_r, dist_amount_r, wet_weight_r, dry_weight_r;
  logic [22:0] crush_step_r;
  logic [12:0] hold_period_r;
  logic        cfg_wr;
  gec_cmd_t    cmd;
  gec_sts_t    sts;

  // register writes complete in the access phase, no wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r     <= 4'd0;
      input_gain_r  <= 16'd4096;
      drive_gain_r  <= 16'd4096;
      dist_amount_r <= 16'd256;
      crush_step_r  <= 23'd1;
      hold_period_r <= 13'd1;
      wet_weight_r  <= 16'd4096;
      dry_weight_r  <= 16'd0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_ENABLES:     enables_r     <= cfg_pwdata[3:0];
        REG_INPUT_GAIN:  input_gain_r  <= cfg_pwdata[15:0];
        REG_DRIVE_GAIN:  drive_gain_r  <= cfg_pwdata[15:0];
        REG_DIST_AMOUNT: dist_amount_r <= cfg_pwdata[15:0];
        REG_CRUSH_STEP:  crush_step_r  <= cfg_pwdata[22:0];
        REG_HOLD_PERIOD: hold_period_r <= cfg_pwdata[12:0];
        REG_WET_WEIGHT:  wet_weight_r  <= cfg_pwdata[15:0];
        REG_DRY_WEIGHT:  dry_weight_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_ENABLES:     cfg_prdata = 32'(enables_r);
      REG_INPUT_GAIN:  cfg_prdata = 32'(input_gain_r);
      REG_DRIVE_GAIN:  cfg_prdata = 32'(drive_gain_r);
      REG_DIST_AMOUNT: cfg_prdata = 32'(dist_amount_r);
      REG_CRUSH_STEP:  cfg_prdata = 32'(crush_step_r);
      REG_HOLD_PERIOD: cfg_prdata = 32'(hold_period_r);
      REG_WET_WEIGHT:  cfg_prdata = 32'(wet_weight_r);
      REG_DRY_WEIGHT:  cfg_prdata = 32'(dry_weight_r);
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // sequencer: one step of the effect chain per state
  gec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .enables  (enables_r),
    .crush_nz (|crush_step_r),
    .sts      (sts),
    .cmd      (cmd)
  );

  // shared multiplier, cordic, divider, hold state and output register
  gec_dp #(
    .CHANNELS (CHANNELS),
    .MAX_HOLD (MAX_HOLD)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .enables     (enables_r),
    .input_gain  (input_gain_r),
    .drive_gain  (drive_gain_r),
    .dist_amount (dist_amount_r),
    .crush_step  (crush_step_r),
    .hold_period (hold_period_r),
    .wet_weight  (wet_weight_r),
    .dry_weight  (dry_weight_r),
    .in_sample   (in_tdata),
    .in_channel  (in_tuser[0]),
    .in_bstart   (in_tuser[1]),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_sample  (out_tdata),
    .out_channel (out_tuser)
  );

endmodule
`default_nettype wire

// File: hw/rtl/gec_div.sv
`default_nettype none
module gec_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [gec_pkg::NUM_W-1:0] dividend,
  input  wire logic [gec_pkg::N_W-1:0]   divisor,
  output logic                          done,
  output logic [gec_pkg::NUM_W-1:0]     quo,
  output logic [gec_pkg::N_W-1:0]       rem
);
  import gec_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   rem_r, den_r;
  logic [NUM_W-1:0] q_r;
  logic [N_W:0]     rem_sh, diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_r, q_r[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    diff   = rem_sh - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[N_W-1:0] : rem_sh[N_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// File: hw/rtl/gec_dp.sv
`default_nettype none
module gec_dp #(
  parameter int CHANNELS = gec_pkg::CHANNELS_DEF,
  parameter int MAX_HOLD = gec_pkg::MAX_HOLD_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire gec_pkg::gec_cmd_t              cmd,
  output gec_pkg::gec_sts_t                   sts,
  input  wire logic [3:0]                     enables,
  input  wire logic [15:0]                    input_gain,
  input  wire logic [15:0]                    drive_gain,
  input  wire logic [15:0]                    dist_amount,
  input  wire logic [22:0]                    crush_step,
  input  wire logic [12:0]                    hold_period,
  input  wire logic [15:0]                    wet_weight,
  input  wire logic [15:0]                    dry_weight,
  input  wire logic [gec_pkg::SAMPLE_BITS-1:0] in_sample,
  input  wire logic                           in_channel,
  input  wire logic                           in_bstart,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [gec_pkg::SAMPLE_BITS-1:0]     out_sample,
  output logic                                out_channel
);
  import gec_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PH_W  = $clog2(MAX_HOLD);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    $signed({{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

  // input word
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic                          ch_r, bstart_r;

  // working values
  logic signed [DRY_W-1:0] dry_r;
  logic signed [WET_W-1:0] wet_r;
  logic                    vneg_r;
  logic signed [CRD_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]   z_r;
  logic [U_W-1:0]          u_r, u2_r, u4_r, u6_r;
  logic [N_W-1:0]          n_r, d_r;
  logic [NUM_W-1:0]        num_r;
  logic signed [SAMPLE_BITS-1:0] res_r;

  // shared multiplier and accumulator
  logic signed [A_W-1:0]   mul_a;
  logic [B_W-1:0]          mul_b;
  logic signed [P_W-1:0]   prod_c, prod_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, prod_ext, fin;
  acc_op_t                 pend_op_r;
  dst_t                    pend_dst_r;

  // per-channel hold state
  logic [PH_W-1:0]               phase_r [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] held_r  [CHANNELS];
  logic [IDX_W-1:0]              idx;
  logic [PH_W-1:0]               ph, ph_next;
  logic [PER_W-1:0]              hp, per, ph_inc;
  logic signed [WET_W-1:0]       wet_eff, wet_mag, crushed, tw;

  // cordic and divider
  logic signed [CRD_W-1:0] xs, ys, v_mag;
  logic signed [Z_W-1:0]   at;
  logic signed [40:0]      v;
  logic [30:0]             zc;
  logic [NUM_W-1:0]        div_num, div_quo;
  logic [N_W-1:0]          div_den, div_rem;
  logic                    div_done;
  logic                    out_valid_r, out_channel_r;
  logic [SAMPLE_BITS-1:0]  out_sample_r;
  logic [ACC_W-38:0]       u_full;

  assign idx = (CHANNELS > 1) ? IDX_W'(ch_r) : '0;

  always_comb begin
    ph = (bstart_r || !enables[EN_HOLD]) ? '0 : phase_r[idx];
    wet_eff = (ph != '0) ? WET_W'(held_r[idx]) : wet_r;
    hp = PER_W'(hold_period);
    if (hp == '0) begin
      per = PER_W'(1);
    end else if (hp > PER_W'(MAX_HOLD)) begin
      per = PER_W'(MAX_HOLD);
    end else begin
      per = hp;
    end
    ph_inc  = PER_W'(ph) + PER_W'(1);
    ph_next = (ph_inc >= per) ? '0 : ph_inc[PH_W-1:0];
  end

  // clamp of the cordic angle to [0, pi/2]
  always_comb begin
    if (z_r[Z_W-1]) begin
      zc = '0;
    end else if (z_r > $signed({2'b00, HALF_PI_Q30})) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = z_r[30:0];
    end
  end

  always_comb begin
    case (cmd.a_sel)
      A_S:       mul_a = A_W'(s_r);
      A_DRY:     mul_a = A_W'(dry_r);
      A_WET:     mul_a = wet_r;
      A_WET_EFF: mul_a = wet_eff;
      A_Z:       mul_a = $signed(A_W'(zc));
      A_U:       mul_a = $signed(A_W'(u_r));
      A_U2:      mul_a = $signed(A_W'(u2_r));
      A_U4:      mul_a = $signed(A_W'(u4_r));
      A_U6:      mul_a = $signed(A_W'(u6_r));
      A_C135135: mul_a = A_W'(135135);
      default:   mul_a = '0;
    endcase
    case (cmd.b_sel)
      B_IG:     mul_b = B_W'(input_gain);
      B_DG:     mul_b = B_W'(drive_gain);
      B_AMT:    mul_b = B_W'(dist_amount);
      B_K2PI:   mul_b = TWO_OVER_PI_Q30;
      B_P23:    mul_b = B_W'(ONE_Q23);
      B_C17325: mul_b = B_W'(17325);
      B_C378:   mul_b = B_W'(378);
      B_ONE:    mul_b = B_W'(1);
      B_C62370: mul_b = B_W'(62370);
      B_C3150:  mul_b = B_W'(3150);
      B_C28:    mul_b = B_W'(28);
      B_NLO:    mul_b = B_W'(n_r[20:0]);
      B_NHI:    mul_b = B_W'(n_r[41:21]);
      B_WW:     mul_b = B_W'(wet_weight);
      B_DW:     mul_b = B_W'(dry_weight);
      B_U:      mul_b = B_W'(u_r);
      B_U2:     mul_b = B_W'(u2_r);
      default:  mul_b = '0;
    endcase
    prod_c = mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (pend_op_r)
      ACC_CLR:   acc_nxt = prod_ext;
      ACC_ADD:   acc_nxt = acc_r + prod_ext;
      ACC_ADD21: acc_nxt = acc_r + (prod_ext <<< 21);
      default:   acc_nxt = acc_r;
    endcase
    fin    = acc_nxt >>> 12;
    v      = $signed(acc_nxt[48:8]);
    v_mag  = v[40] ? -CRD_W'(v) : CRD_W'(v);
    u_full = acc_nxt[ACC_W-1:37];
  end

  always_comb begin
    xs = x_r >>> cmd.cord_idx;
    ys = y_r >>> cmd.cord_idx;
    at = $signed(Z_W'(atan_q30(cmd.cord_idx)));
    wet_mag = wet_r[WET_W-1] ? -wet_r : wet_r;
    crushed = wet_mag - $signed(WET_W'(div_rem));
    tw      = $signed(WET_W'(div_quo[U_W-1:0]));
    div_num = cmd.div_crush ? NUM_W'(wet_mag) : num_r;
    div_den = cmd.div_crush ? N_W'(crush_step) : d_r;
  end

  gec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_op_r  <= ACC_NONE;
      pend_dst_r <= DST_NONE;
    end else if (cmd.mul_go) begin
      pend_op_r  <= cmd.acc_op;
      pend_dst_r <= cmd.dst;
    end else begin
      pend_op_r  <= ACC_NONE;
      pend_dst_r <= DST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    acc_r  <= acc_nxt;
    if (cmd.ld_in) begin
      s_r      <= in_sample;
      ch_r     <= in_channel;
      bstart_r <= in_bstart;
    end
    case (pend_dst_r)
      DST_DRY: begin
        dry_r <= $signed(acc_nxt[39:12]);
        wet_r <= WET_W'($signed(acc_nxt[39:12]));
      end
      DST_WET: wet_r <= $signed(acc_nxt[45:12]);
      DST_V: begin
        vneg_r <= v[40];
        x_r    <= CRD_W'(ONE_Q23);
        y_r    <= v_mag;
        z_r    <= '0;
      end
      DST_U:   u_r  <= (u_full > ($bits(u_full))'(ONE_Q23)) ? ONE_Q23 : u_full[U_W-1:0];
      DST_U2:  u2_r <= acc_nxt[46:23];
      DST_U4:  u4_r <= acc_nxt[46:23];
      DST_U6:  u6_r <= acc_nxt[46:23];
      DST_N:   n_r  <= acc_nxt[N_W-1:0];
      DST_D:   d_r  <= acc_nxt[N_W-1:0];
      DST_NUM: num_r <= acc_nxt[NUM_W-1:0];
      DST_FIN: begin
        if (fin > SAT_HI) begin
          res_r <= SAT_HI[SAMPLE_BITS-1:0];
        end else if (fin < SAT_LO) begin
          res_r <= SAT_LO[SAMPLE_BITS-1:0];
        end else begin
          res_r <= fin[SAMPLE_BITS-1:0];
        end
      end
      default: ;
    endcase
    if (cmd.cord_step) begin
      if (!y_r[CRD_W-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
    if (cmd.div_wb) begin
      if (cmd.div_crush) begin
        wet_r <= wet_r[WET_W-1] ? -crushed : crushed;
      end else begin
        wet_r <= vneg_r ? -tw : tw;
      end
    end
    if (cmd.commit) begin
      out_sample_r  <= res_r;
      out_channel_r <= ch_r;
      if (ph == '0) begin
        held_r[idx] <= res_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      if (cmd.commit) begin
        out_valid_r  <= 1'b1;
        phase_r[idx] <= enables[EN_HOLD] ? ph_next : '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_channel  = out_channel_r;

endmodule
`default_nettype wire

// File: hw/rtl/gec_ctrl.sv
`default_nettype none
module gec_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        enables,
  input  wire logic              crush_nz,
  input  wire gec_pkg::gec_sts_t sts,
  output gec_pkg::gec_cmd_t      cmd
);
  import gec_pkg::*;

  gec_state_t        state_r, state_nxt, after_op, post_wet;
  logic              sub_r, sub_nxt;
  logic [IDX_CW-1:0] cnt_r, cnt_nxt;
  a_sel_t            a_sel;
  b_sel_t            b_sel;
  acc_op_t           acc_op;
  dst_t              dst;
  logic              is_mul;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sub_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // micro-op of each multiply state and where it leads
  always_comb begin
    post_wet = (enables[EN_CRUSH] && crush_nz) ? ST_CDIV : ST_F0;
    is_mul   = 1'b1;
    a_sel    = A_S;
    b_sel    = B_IG;
    acc_op   = ACC_CLR;
    dst      = DST_NONE;
    after_op = ST_IDLE;
    case (state_r)
      ST_DRY: begin
        dst = DST_DRY;
        after_op = enables[EN_DRIVE] ? ST_DRV : (enables[EN_DIST] ? ST_AMT : post_wet);
      end
      ST_DRV: begin
        a_sel = A_WET; b_sel = B_DG; dst = DST_WET;
        after_op = enables[EN_DIST] ? ST_AMT : post_wet;
      end
      ST_AMT: begin a_sel = A_WET; b_sel = B_AMT; dst = DST_V; after_op = ST_CORD; end
      ST_U:   begin a_sel = A_Z; b_sel = B_K2PI; dst = DST_U; after_op = ST_U2; end
      // u squared, and the even powers built from it
      ST_U2:  begin a_sel = A_U; b_sel = B_U; dst = DST_U2; after_op = ST_U4; end
      ST_U4:  begin a_sel = A_U2; b_sel = B_U2; dst = DST_U4; after_op = ST_U6; end
      ST_U6:  begin a_sel = A_U4; b_sel = B_U2; dst = DST_U6; after_op = ST_N0; end
      ST_N0:  begin a_sel = A_C135135; b_sel = B_P23; after_op = ST_N1; end
      ST_N1:  begin a_sel = A_U2; b_sel = B_C17325; acc_op = ACC_ADD; after_op = ST_N2; end
      ST_N2:  begin a_sel = A_U4; b_sel = B_C378; acc_op = ACC_ADD; after_op = ST_N3; end
      ST_N3:  begin
        a_sel = A_U6; b_sel = B_ONE; acc_op = ACC_ADD; dst = DST_N; after_op = ST_D0;
      end
      ST_D0:  begin a_sel = A_C135135; b_sel = B_P23; after_op = ST_D1; end
      ST_D1:  begin a_sel = A_U2; b_sel = B_C62370; acc_op = ACC_ADD; after_op = ST_D2; end
      ST_D2:  begin a_sel = A_U4; b_sel = B_C3150; acc_op = ACC_ADD; after_op = ST_D3; end
      ST_D3:  begin
        a_sel = A_U6; b_sel = B_C28; acc_op = ACC_ADD; dst = DST_D; after_op = ST_P0;
      end
      ST_P0:  begin a_sel = A_U; b_sel = B_NLO; after_op = ST_P1; end
      ST_P1:  begin
        a_sel = A_U; b_sel = B_NHI; acc_op = ACC_ADD21; dst = DST_NUM; after_op = ST_TDIV;
      end
      ST_F0:  begin a_sel = A_WET_EFF; b_sel = B_WW; after_op = ST_F1; end
      ST_F1:  begin
        a_sel = A_DRY; b_sel = B_DW; acc_op = ACC_ADD; dst = DST_FIN; after_op = ST_DONE;
      end
      default: is_mul = 1'b0;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    sub_nxt   = sub_r;
    cnt_nxt   = cnt_r;
    cmd.a_sel  = a_sel;
    cmd.b_sel  = b_sel;
    cmd.acc_op = acc_op;
    cmd.dst    = dst;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_DRY;
          sub_nxt   = 1'b0;
        end
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        cmd.cord_idx  = cnt_r;
        if (cnt_r == IDX_CW'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_U;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_TDIV, ST_CDIV: begin
        cmd.div_crush = (state_r == ST_CDIV);
        if (!sub_r) begin
          cmd.div_go = 1'b1;
          sub_nxt    = 1'b1;
        end else if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          sub_nxt    = 1'b0;
          state_nxt  = (state_r == ST_TDIV) ? post_wet : ST_F0;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        if (is_mul) begin
          if (!sub_r) begin
            cmd.mul_go = 1'b1;
            sub_nxt    = 1'b1;
          end else begin
            sub_nxt   = 1'b0;
            state_nxt = after_op;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_go |-> (state_r == ST_TDIV || state_r == ST_CDIV))
    else $error("divider started outside a divide step");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("result committed over an untaken word");

  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_in |=> (state_r == ST_DRY && !sub_r))
    else $error("accepted word did not start processing");

endmodule
`default_nettype wire
